>>> design/rlcm_pkg.sv
package rlcm_pkg;

  // Width of one signed list element on the input port.
  localparam int unsigned ValueBits = 32;

  // Width of the running multiple and of the result.
  localparam int unsigned LcmWidth = 31;

  // Largest representable multiple; larger values saturate here.
  localparam logic [LcmWidth-1:0] LcmLimit = '1;

  // The divider retires one quotient bit per cycle.
  localparam int unsigned DivSteps   = LcmWidth;
  localparam int unsigned DivCntBits = $clog2(DivSteps);

  // Full product of a quotient and the smaller operand.
  localparam int unsigned ProdWidth = 2 * LcmWidth;

  // Request to the shared divider.
  typedef struct packed {
    logic                start;
    logic [LcmWidth-1:0] dividend;
    logic [LcmWidth-1:0] divisor;
  } div_req_t;

  // Response from the shared divider; the results are valid with done.
  typedef struct packed {
    logic                done;
    logic [LcmWidth-1:0] quotient;
    logic [LcmWidth-1:0] remainder;
  } div_rsp_t;

endpackage

>>> design/rlcm_div.sv
module rlcm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rlcm_pkg::div_req_t req_i,
  output rlcm_pkg::div_rsp_t rsp_o
);
  import rlcm_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DivCntBits-1:0] cnt_q, cnt_d;
  logic [LcmWidth-1:0]   rem_q, rem_d;
  logic [LcmWidth-1:0]   quo_q, quo_d;
  logic [LcmWidth-1:0]   dvs_q, dvs_d;

  logic [LcmWidth:0]     shifted;
  logic [LcmWidth:0]     dvs_ext;
  logic                  fits;

  // One restoring step: shift in the next dividend bit and try a subtraction.
  assign shifted = {rem_q, quo_q[LcmWidth-1]};
  assign dvs_ext = {1'b0, dvs_q};
  assign fits    = (shifted >= dvs_ext);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntBits'(DivSteps - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? LcmWidth'(shifted - dvs_ext) : shifted[LcmWidth-1:0];
      quo_d = {quo_q[LcmWidth-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  // Control flops are reset; the datapath registers are loaded on start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> design/running_lcm_of_list.sv
// Running least common multiple of a list of signed integers.
// Input channel: in_valid_i/in_ready_o carry one list element (value_i) and a
// flag (last_i) that marks the final element of the list. Only the absolute
// value of an element is used; a magnitude above 2^31-1 saturates.
// Output channel: out_valid_o/out_ready_i carry one item per list, holding the
// least common multiple (lcm_result_o) and a sticky overflow flag (overflow_o).
// No item is produced for elements that are not marked last.
// The first element of a list, or an element that meets a zero, is settled in
// the idle state. Any other element runs Euclid's algorithm on a shared
// bit-serial divider: one division for each remainder step and one for the
// final quotient, then a multiply step and a saturation step. in_ready_o is
// low while an element runs. The result sits in an output register; the block
// takes new elements while it waits, and only stalls a later list end until
// the receiver takes the result.
// Reset clears the running multiple, the overflow flag and the output valid.
module running_lcm_of_list (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [rlcm_pkg::ValueBits-1:0] value_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rlcm_pkg::LcmWidth-1:0]       lcm_result_o,
  output logic                                overflow_o
);
  import rlcm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_QUOT,
    ST_MUL,
    ST_SAT,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic                started_q;
  logic                ovf_q;
  logic                last_q;
  logic [LcmWidth-1:0] run_q;
  logic [LcmWidth-1:0] hi_q;
  logic [LcmWidth-1:0] lo_q;
  logic [LcmWidth-1:0] b_q;
  logic [LcmWidth-1:0] quo_q;
  logic [ProdWidth-1:0] prod_q;
  div_req_t            req_q;
  div_rsp_t            rsp;
  logic                out_valid_q;
  logic [LcmWidth-1:0] out_lcm_q;
  logic                out_ovf_q;

  logic [ValueBits-1:0] mag_full;
  logic [63:0]          mag_wide;
  logic                 mag_ovf;
  logic [LcmWidth-1:0]  mag;
  logic                 accept;
  logic                 a_bigger;
  logic [LcmWidth-1:0]  hi_c;
  logic [LcmWidth-1:0]  lo_c;
  logic                 out_free;
  logic                 div_start_d;
  logic                 out_valid_d;

  // Magnitude of the element, saturated to the result range.
  assign mag_full = value_i[ValueBits-1] ? (~value_i + 1'b1) : value_i;
  assign mag_wide = 64'(mag_full);
  assign mag_ovf  = (mag_wide > 64'(LcmLimit));
  assign mag      = mag_ovf ? LcmLimit : mag_wide[LcmWidth-1:0];

  // Order the running multiple and the new magnitude.
  assign a_bigger = (run_q > mag);
  assign hi_c     = a_bigger ? run_q : mag;
  assign lo_c     = a_bigger ? mag : run_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // A division starts for a new pair of non-zero operands and after every
  // finished division while the Euclid loop runs.
  assign div_start_d = (accept && started_q && (lo_c != '0)) ||
                       ((state_q == ST_GCD) && rsp.done);

  // The output item is loaded from the emit state and held until taken.
  assign out_valid_d = ((state_q == ST_EMIT) && out_free) ||
                       (out_valid_q && !out_ready_i);

  rlcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_q),
    .rsp_o  (rsp)
  );

  // Sequencer: Euclid loop on the divider, then quotient, multiply, saturate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      started_q    <= 1'b0;
      ovf_q        <= 1'b0;
      last_q       <= 1'b0;
      run_q        <= '0;
      req_q        <= '0;
      out_valid_q  <= 1'b0;
      out_lcm_q    <= '0;
      out_ovf_q    <= 1'b0;
      hi_q         <= '0;
      lo_q         <= '0;
      b_q          <= '0;
      quo_q        <= '0;
      prod_q       <= '0;
    end else begin
      req_q.start <= div_start_d;
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            last_q <= last_i;
            if (mag_ovf) begin
              ovf_q <= 1'b1;
            end
            if (!started_q) begin
              run_q     <= mag;
              started_q <= 1'b1;
              state_q   <= last_i ? ST_EMIT : ST_IDLE;
            end else if (lo_c == '0) begin
              run_q   <= '0;
              state_q <= last_i ? ST_EMIT : ST_IDLE;
            end else begin
              hi_q           <= hi_c;
              lo_q           <= lo_c;
              b_q            <= lo_c;
              req_q.dividend <= hi_c;
              req_q.divisor  <= lo_c;
              state_q        <= ST_GCD;
            end
          end
        end
        ST_GCD: begin
          if (rsp.done) begin
            if (rsp.remainder == '0) begin
              // b_q is the greatest common divisor: divide the larger operand.
              req_q.dividend <= hi_q;
              req_q.divisor  <= b_q;
              state_q        <= ST_QUOT;
            end else begin
              req_q.dividend <= b_q;
              req_q.divisor  <= rsp.remainder;
              b_q            <= rsp.remainder;
            end
          end
        end
        ST_QUOT: begin
          if (rsp.done) begin
            quo_q   <= rsp.quotient;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_q  <= ProdWidth'(quo_q) * ProdWidth'(lo_q);
          state_q <= ST_SAT;
        end
        ST_SAT: begin
          if (prod_q[ProdWidth-1:LcmWidth] != '0) begin
            run_q <= LcmLimit;
            ovf_q <= 1'b1;
          end else begin
            run_q <= prod_q[LcmWidth-1:0];
          end
          state_q <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          // Hand the result to the output register and open a new list.
          if (out_free) begin
            out_lcm_q   <= run_q;
            out_ovf_q   <= ovf_q;
            run_q       <= '0;
            started_q   <= 1'b0;
            ovf_q       <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign lcm_result_o = out_lcm_q;
  assign overflow_o   = out_ovf_q;

endmodule

>>> design/rlcm_checker.sv
module rlcm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          last_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [rlcm_pkg::LcmWidth-1:0] lcm_result_o,
  input logic                          overflow_o
);
  import rlcm_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(lcm_result_o) && $stable(overflow_o))
    else $error("result changed while stalled");

  // A result is only withdrawn once it has been taken.
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_o) |-> $past(out_ready_i))
    else $error("result dropped without being taken");

  // An element that does not end a list never brings a new result.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !last_i |=> !$rose(out_valid_o))
    else $error("result raised by an element not marked last");

  // Leaving reset, no result is pending.
  a_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight after reset");

endmodule

bind running_lcm_of_list rlcm_checker u_rlcm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .last_i       (last_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .lcm_result_o (lcm_result_o),
  .overflow_o   (overflow_o)
);
